### rtl/length_prefixed_message_deframer_core_assert.svh
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_core_assert.svh
// assertion macros for the deframer, empty bodies under synthesis
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define LPMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked during reset too
`define LPMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LPMD_ASSERT(lbl, prop, msg)
`define LPMD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/lpmd_pkg.sv
// ----------------------------------------------------------------------------
// lpmd_pkg
// types, codes and constants shared by the deframer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpmd_pkg;

  // result kinds
  localparam logic [1:0] K_PAYLOAD = 2'd0;
  localparam logic [1:0] K_EMPTY   = 2'd1;
  localparam logic [1:0] K_ERROR   = 2'd2;

  // error codes
  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_ID   = 2'd1;
  localparam logic [1:0] E_LEN  = 2'd2;
  localparam logic [1:0] E_LINK = 2'd3;

  // parser phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HALTED  = 2'd2;

  // configuration port
  localparam int unsigned LPMD_PADDR_W = 3;
  localparam int unsigned LPMD_PDATA_W = 32;
  localparam logic [0:0]  REG_MAX_MSG_LEN = 1'b0;
  localparam logic [15:0] MAX_MSG_LEN_RST = 16'd2048;

  // default depth of the queue between parser and output stage
  localparam int unsigned LPMD_QDEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       link_error;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  err_code;
    logic [15:0] msg_id;
    logic [15:0] msg_len;
    logic [7:0]  payload_byte;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/lpmd_front.sv
// ----------------------------------------------------------------------------
// lpmd_front
// header parser: classifies each accepted byte and issues at most one result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpmd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  lpmd_pkg::in_item_t  item,
  input  logic [15:0]         max_msg_len,
  output logic                res_vld,
  output lpmd_pkg::out_item_t res
);
  import lpmd_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [15:0] hid_r, hid_nxt;
  logic [15:0] hlen_r, hlen_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        is_last;

  assign is_last = (rem_r <= 16'd1);

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    hid_nxt   = hid_r;
    hlen_nxt  = hlen_r;
    rem_nxt   = rem_r;
    res_vld   = 1'b0;
    res.kind         = K_PAYLOAD;
    res.err_code     = E_NONE;
    res.msg_id       = hid_r;
    res.msg_len      = hlen_r;
    res.payload_byte = 8'h00;
    res.last         = 1'b0;

    if (accept && (phase_r == PH_HEADER || phase_r == PH_PAYLOAD)) begin
      if (item.link_error) begin
        // header fields as they stand, possibly half assembled
        phase_nxt    = PH_HALTED;
        res_vld      = 1'b1;
        res.kind     = K_ERROR;
        res.err_code = E_LINK;
      end else if (phase_r == PH_HEADER) begin
        unique case (hcnt_r)
          2'd0:    hid_nxt  = {item.data_byte, 8'h00};
          2'd1:    hid_nxt  = {hid_r[15:8], item.data_byte};
          2'd2:    hlen_nxt = {item.data_byte, 8'h00};
          default: hlen_nxt = {hlen_r[15:8], item.data_byte};
        endcase
        if (hcnt_r != 2'd3) begin
          hcnt_nxt = hcnt_r + 2'd1;
        end else begin
          hcnt_nxt    = 2'd0;
          res.msg_id  = hid_nxt;
          res.msg_len = hlen_nxt;
          // id check wins over length check
          priority if (hid_nxt > max_msg_len) begin
            phase_nxt    = PH_HALTED;
            res_vld      = 1'b1;
            res.kind     = K_ERROR;
            res.err_code = E_ID;
          end else if (hlen_nxt > max_msg_len) begin
            phase_nxt    = PH_HALTED;
            res_vld      = 1'b1;
            res.kind     = K_ERROR;
            res.err_code = E_LEN;
          end else if (hlen_nxt == 16'd0) begin
            res_vld  = 1'b1;
            res.kind = K_EMPTY;
            res.last = 1'b1;
          end else begin
            rem_nxt   = hlen_nxt;
            phase_nxt = PH_PAYLOAD;
          end
        end
      end else begin
        res_vld          = 1'b1;
        res.payload_byte = item.data_byte;
        res.last         = is_last;
        if (is_last) begin
          rem_nxt   = 16'd0;
          phase_nxt = PH_HEADER;
          hcnt_nxt  = 2'd0;
        end else begin
          rem_nxt = rem_r - 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= 2'd0;
      hid_r   <= 16'd0;
      hlen_r  <= 16'd0;
      rem_r   <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      hid_r   <= hid_nxt;
      hlen_r  <= hlen_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

### rtl/lpmd_queue.sv
// ----------------------------------------------------------------------------
// lpmd_queue
// short result queue between parser and output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpmd_queue #(
  parameter int unsigned DEPTH = lpmd_pkg::LPMD_QDEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  lpmd_pkg::out_item_t wr_data,
  input  logic                rd_en,
  output lpmd_pkg::out_item_t rd_data,
  output lpmd_pkg::q_stat_t   stat
);
  import lpmd_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  out_item_t       mem [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign do_wr = wr_en && !stat.full;
  assign do_rd = rd_en && !stat.empty;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    if (do_rd) rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    if (do_wr && !do_rd) cnt_nxt = cnt_r + CW'(1);
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/lpmd_back.sv
// ----------------------------------------------------------------------------
// lpmd_back
// output register: presents the oldest result and refills from the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpmd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lpmd_pkg::out_item_t q_head,
  input  lpmd_pkg::q_stat_t   q_stat,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output lpmd_pkg::out_item_t out_data
);
  import lpmd_pkg::*;

  logic      vld_r, vld_nxt;
  out_item_t data_r;

  // refill when the register is free or being taken this cycle
  assign q_pop   = !q_stat.empty && (!vld_r || pop);
  assign vld_nxt = q_pop ? 1'b1 : (pop ? 1'b0 : vld_r);

  assign empty    = !vld_r;
  assign out_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) data_r <= q_head;
  end

endmodule

### rtl/length_prefixed_message_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_core
// splits a byte stream into id-tagged, length-prefixed messages
// ----------------------------------------------------------------------------
//  channel   ports                                  direction  word
//  input     push, full, in_data                    in         one stream byte
//  result    pop, empty, out_data                   out        one result
//  config    psel penable pwrite paddr pwdata ...   in/out     max_msg_len
//
//  one byte accepted per cycle, sustained while full is low
//  the accepting edge writes the result queue; the result moves on to the output
//  ports once the output register is free or being popped
//  synchronous reset, no clearing pass; max_msg_len returns to 2048
//  full rises when the result queue is full and the output register holds,
//  which happens only while pop is held low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "length_prefixed_message_deframer_core_assert.svh"

module length_prefixed_message_deframer_core #(
  parameter int unsigned QDEPTH = lpmd_pkg::LPMD_QDEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                push,
  output logic                                full,
  input  lpmd_pkg::in_item_t                  in_data,
  // result channel
  input  logic                                pop,
  output logic                                empty,
  output lpmd_pkg::out_item_t                 out_data,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpmd_pkg::LPMD_PADDR_W-1:0]   paddr,
  input  logic [lpmd_pkg::LPMD_PDATA_W-1:0]   pwdata,
  output logic [lpmd_pkg::LPMD_PDATA_W-1:0]   prdata,
  output logic                                pready
);
  import lpmd_pkg::*;

  logic        in_acc;
  logic        fe_vld;
  out_item_t   fe_res;
  out_item_t   q_head;
  q_stat_t     q_stat;
  logic        q_pop;
  logic [15:0] max_msg_len_r;
  logic        reg_hit;

  // configuration register, word 0 only; upper address bit selects beyond list
  assign pready  = 1'b1;
  assign reg_hit = (paddr[LPMD_PADDR_W-1 -: 1] == REG_MAX_MSG_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msg_len_r <= MAX_MSG_LEN_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_msg_len_r <= pwdata[15:0];
    end
  end

  assign prdata = reg_hit ? {{(LPMD_PDATA_W-16){1'b0}}, max_msg_len_r} : '0;

  // a byte goes in whenever the queue has room for its possible result
  assign full   = q_stat.full;
  assign in_acc = push && !full;

  lpmd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .item        (in_data),
    .max_msg_len (max_msg_len_r),
    .res_vld     (fe_vld),
    .res         (fe_res)
  );

  lpmd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fe_vld),
    .wr_data (fe_res),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .stat    (q_stat)
  );

  lpmd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

  // a parser result never meets a full queue
  `LPMD_ASSERT(a_no_lost_result, fe_vld |-> !q_stat.full, "result pushed into full queue")
  // after an error the parser stays silent until reset
  `LPMD_ASSERT(a_halt_after_error, (fe_vld && fe_res.kind == K_ERROR) |=> !fe_vld, "result after error")
  // output register fills only from a waiting queue entry
  `LPMD_ASSERT(a_fill_from_queue, $fell(empty) |-> $past(!q_stat.empty), "output filled from empty queue")
  // nothing is shown after a reset edge
  `LPMD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty, "result present after reset")

endmodule

### test/length_prefixed_message_deframer_core_test.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer_core_test
// self-checking bench for the message deframer: a directed table of stream
// bytes, then random well-formed messages under several length limits, with
// both queue sides idling at random, checked word by word against a model of
// the header/payload parser; the run ends on one fatal header or link fault
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_message_deframer_core_test;
  import lpmd_pkg::*;

  // register map: one register, byte addressed, 4 bytes apart
  localparam int unsigned LIMIT_INDEX = int'(REG_MAX_MSG_LEN);
  localparam logic [LPMD_PADDR_W-1:0] LIMIT_ADDR = LPMD_PADDR_W'(LIMIT_INDEX * 4);
  // first address past the register list, writes there must be dropped
  localparam logic [LPMD_PADDR_W-1:0] STRAY_ADDR = LPMD_PADDR_W'((LIMIT_INDEX + 1) * 4);

  // receiver hold-off used to back the block up into full
  localparam int unsigned LONG_HOLD = 60;
  // cycles a byte may still be in flight after the last result came out
  localparam int unsigned FLIGHT = 4;

  typedef enum {ROW_WORD, ROW_LIMIT, ROW_STRAY} row_op_t;
  typedef enum {FAULT_LINK_HEADER, FAULT_LINK_PAYLOAD, FAULT_ID, FAULT_LEN, FAULT_BOTH} fault_t;

  // one row of the directed table; the result fields count only when typed
  typedef struct {
    row_op_t     op;
    logic [15:0] arg;
    logic        typed;
    logic [1:0]  kind;
    logic [1:0]  code;
    logic [15:0] id;
    logic [15:0] len;
    logic [7:0]  pbyte;
    logic        last;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    push = 1'b0;
  logic                    full;
  in_item_t                in_data = '0;
  logic                    pop = 1'b0;
  logic                    empty;
  out_item_t               out_data;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [LPMD_PADDR_W-1:0] paddr = '0;
  logic [LPMD_PDATA_W-1:0] pwdata = '0;
  logic [LPMD_PDATA_W-1:0] prdata;
  logic                    pready;

  length_prefixed_message_deframer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // parser model: its own copy of the limit and of the header state
  // --------------------------------------------------------------------------
  logic [15:0] limit = MAX_MSG_LEN_RST;
  logic [1:0]  ph = PH_HEADER;
  logic [2:0]  hdr_cnt = '0;
  logic [15:0] hdr_id = '0;
  logic [15:0] hdr_len = '0;
  logic [15:0] remain = '0;

  // results the block still owes, oldest first
  out_item_t expected_words[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;

  // every result carries the header as it stands
  function automatic out_item_t result_word(logic [1:0] kind, logic [1:0] code,
                                            logic [7:0] pbyte, logic last);
    out_item_t w;
    w.kind         = kind;
    w.err_code     = code;
    w.msg_id       = hdr_id;
    w.msg_len      = hdr_len;
    w.payload_byte = pbyte;
    w.last         = last;
    return w;
  endfunction

  // advance the model by one stream byte, 1 when it yields a result
  function automatic bit deframe_step(input in_item_t word, output out_item_t res);
    logic [7:0] b;
    logic       is_last;
    b   = word.data_byte;
    res = '0;
    // halted (and the unused phase code) swallows everything
    if (ph != PH_HEADER && ph != PH_PAYLOAD) return 1'b0;
    // link failure wins over the byte, header may be half built
    if (word.link_error) begin
      ph  = PH_HALTED;
      res = result_word(K_ERROR, E_LINK, 8'h00, 1'b0);
      return 1'b1;
    end
    if (ph == PH_HEADER) begin
      case (hdr_cnt[1:0])
        2'd0: hdr_id = {b, 8'h00};
        2'd1: hdr_id[7:0] = b;
        2'd2: hdr_len = {b, 8'h00};
        default: hdr_len[7:0] = b;
      endcase
      if (hdr_cnt[1:0] != 2'd3) begin
        hdr_cnt = hdr_cnt[1:0] + 3'd1;
        return 1'b0;
      end
      hdr_cnt = '0;
      // id is judged before length
      if (hdr_id > limit) begin
        ph  = PH_HALTED;
        res = result_word(K_ERROR, E_ID, 8'h00, 1'b0);
        return 1'b1;
      end
      if (hdr_len > limit) begin
        ph  = PH_HALTED;
        res = result_word(K_ERROR, E_LEN, 8'h00, 1'b0);
        return 1'b1;
      end
      if (hdr_len == 16'd0) begin
        res = result_word(K_EMPTY, E_NONE, 8'h00, 1'b1);
        return 1'b1;
      end
      remain = hdr_len;
      ph     = PH_PAYLOAD;
      return 1'b0;
    end
    // payload byte
    is_last = (remain <= 16'd1);
    res = result_word(K_PAYLOAD, E_NONE, b, is_last);
    if (is_last) begin
      remain  = '0;
      ph      = PH_HEADER;
      hdr_cnt = '0;
    end else begin
      remain = remain - 16'd1;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // result side: checks each popped word, idles in bursts, long hold on demand
  // --------------------------------------------------------------------------
  bit          no_idle = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_burst = 0;
  int unsigned rx_calm = 0;

  task automatic check_word(input out_item_t got);
    out_item_t want;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: kind %0d code %0d id %h len %h byte %h last %0d",
                 got.kind, got.err_code, got.msg_id, got.msg_len,
                 got.payload_byte, got.last);
      return;
    end
    want = expected_words.pop_front();
    if (got.kind !== want.kind || got.err_code !== want.err_code ||
        got.msg_id !== want.msg_id || got.msg_len !== want.msg_len ||
        got.payload_byte !== want.payload_byte || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word mismatch (exp/got): kind %0d/%0d code %0d/%0d id %h/%h len %h/%h %s",
                 want.kind, got.kind, want.err_code, got.err_code,
                 want.msg_id, got.msg_id, want.msg_len, got.msg_len,
                 $sformatf("byte %h/%h last %0d/%0d", want.payload_byte,
                           got.payload_byte, want.last, got.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      // values seen here are the ones from before this edge
      if (pop && !empty) check_word(out_data);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        // long hold-off, lets the queue fill and full rise
        hold_left--;
        pop <= 1'b0;
      end else if (no_idle) begin
        pop <= 1'b1;
      end else if (rx_burst > 0) begin
        rx_burst--;
        pop <= 1'b0;
      end else if (rx_calm > 0) begin
        rx_calm--;
        pop <= 1'b1;
      end else begin
        case ($urandom_range(0, 7))
          0: begin
            // stretch with no stalls at all
            rx_calm = $urandom_range(16, 80);
            pop <= 1'b1;
          end
          1, 2: begin
            // stall burst of random length, this one included
            rx_burst = $urandom_range(1, 7) - 1;
            pop <= 1'b0;
          end
          default: pop <= 1'b1;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // stream side
  // --------------------------------------------------------------------------
  int unsigned tx_calm = 0;

  // offer one word, maybe after an idle burst, and book its result on accept
  task automatic offer(input in_item_t word, input bit typed, input out_item_t want);
    out_item_t   predicted;
    bit          has;
    int unsigned gap;
    logic [31:0] junk;
    gap = 0;
    if (!no_idle) begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else begin
        case ($urandom_range(0, 7))
          0: tx_calm = $urandom_range(16, 80);
          1, 2: gap = $urandom_range(1, 7);
          default: gap = 0;
        endcase
      end
    end
    if (gap > 0) begin
      junk = $urandom;
      push    <= 1'b0;
      in_data <= junk[8:0];
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= word;
    do @(posedge clk); while (full);
    // accepted at this edge; push stays high until the next decision
    has = deframe_step(word, predicted);
    if (typed) expected_words.insert(expected_words.size(), want);
    else if (has) expected_words.insert(expected_words.size(), predicted);
    words_sent++;
  endtask

  task automatic offer_byte(input logic [7:0] b, input logic link_err);
    in_item_t w;
    w.data_byte  = b;
    w.link_error = link_err;
    offer(w, 1'b0, '0);
  endtask

  task automatic send_header(input logic [15:0] id, input logic [15:0] len);
    offer_byte(id[15:8], 1'b0);
    offer_byte(id[7:0], 1'b0);
    offer_byte(len[15:8], 1'b0);
    offer_byte(len[7:0], 1'b0);
  endtask

  task automatic send_message(input logic [15:0] id, input logic [15:0] len);
    send_header(id, len);
    for (int i = 0; i < len; i++) offer_byte(8'($urandom), 1'b0);
  endtask

  // stop sending and wait until the block has nothing left in flight
  task automatic settle();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (FLIGHT) @(posedge clk);
  endtask

  // one APB transfer: setup phase, access phase, then an idle phase
  task automatic cfg_access(input bit wr, input logic [LPMD_PADDR_W-1:0] addr,
                            input logic [LPMD_PDATA_W-1:0] wdata,
                            output logic [LPMD_PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // write while idle, then read the limit back
  task automatic reg_write(input logic [LPMD_PADDR_W-1:0] addr, input logic [15:0] value);
    logic [LPMD_PDATA_W-1:0] rd;
    settle();
    cfg_access(1'b1, addr, LPMD_PDATA_W'(value), rd);
    if (addr == LIMIT_ADDR) limit = value;
    cfg_access(1'b0, LIMIT_ADDR, '0, rd);
    if (rd[15:0] !== limit) begin
      mismatches++;
      if (mismatches <= 10)
        $display("limit readback mismatch: expected %h got %h", limit, rd[15:0]);
    end
  endtask

  // --------------------------------------------------------------------------
  // directed table: extremes at the limit, empty and one-byte messages,
  // out-of-list register write
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [29];

  initial begin
    directed_rows = '{
      // id at the reset limit, zero length: empty message
      '{ROW_WORD,  16'h0008, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b1, K_EMPTY,   E_NONE, 16'h0800, 16'h0000, 8'h00, 1'b1},
      // id zero, one all-ones byte
      '{ROW_WORD,  16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0001, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h00ff, 1'b1, K_PAYLOAD, E_NONE, 16'h0000, 16'h0001, 8'hff, 1'b1},
      // widest limit, all-ones id
      '{ROW_LIMIT, 16'hffff, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h00ff, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h00ff, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0002, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b1, K_PAYLOAD, E_NONE, 16'hffff, 16'h0002, 8'h00, 1'b0},
      '{ROW_WORD,  16'h00a5, 1'b1, K_PAYLOAD, E_NONE, 16'hffff, 16'h0002, 8'ha5, 1'b1},
      // zero limit: only the all-zero header passes
      '{ROW_LIMIT, 16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b1, K_EMPTY,   E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b1},
      // write past the register list must leave the limit alone
      '{ROW_STRAY, 16'h0001, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      // small limit, id and length both right at it
      '{ROW_LIMIT, 16'h0002, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0002, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0000, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h0002, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h005a, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0},
      '{ROW_WORD,  16'h00c3, 1'b0, K_PAYLOAD, E_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0}
    };
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] phase_limits [6];
    logic [15:0] id;
    logic [15:0] len;
    int unsigned cap;
    int unsigned start;
    int unsigned msgs;
    int unsigned waited;
    int unsigned cut;
    in_item_t    w;
    out_item_t   want;
    fault_t      fault;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      case (directed_rows[i].op)
        ROW_LIMIT: reg_write(LIMIT_ADDR, directed_rows[i].arg);
        ROW_STRAY: reg_write(STRAY_ADDR, directed_rows[i].arg);
        default: begin
          w.data_byte       = directed_rows[i].arg[7:0];
          w.link_error      = 1'b0;
          want.kind         = directed_rows[i].kind;
          want.err_code     = directed_rows[i].code;
          want.msg_id       = directed_rows[i].id;
          want.msg_len      = directed_rows[i].len;
          want.payload_byte = directed_rows[i].pbyte;
          want.last         = directed_rows[i].last;
          offer(w, directed_rows[i].typed, want);
        end
      endcase
    end

    // random messages, one limit setting per phase, extremes included
    phase_limits = '{16'hffff, 16'h0000, 16'd9, 16'($urandom_range(10, 65534)),
                     MAX_MSG_LEN_RST, 16'd1};
    foreach (phase_limits[p]) begin
      reg_write(LIMIT_ADDR, phase_limits[p]);
      start = words_sent;
      msgs  = 0;
      while (words_sent - start < 110) begin
        // id at the limit now and then, else anywhere up to it
        id  = ($urandom_range(0, 3) == 0) ? limit : 16'($urandom_range(limit, 0));
        cap = (limit < 12) ? limit : 12;
        if ($urandom_range(0, 15) == 0) cap = (limit < 48) ? limit : 48;
        case ($urandom_range(0, 7))
          0: len = 16'd0;
          1: len = 16'(cap);
          default: len = 16'($urandom_range(cap, 0));
        endcase
        send_message(id, len);
        msgs++;
        // receiver backs off for a long while as bytes keep coming
        if (p == 0 && msgs == 6) hold_req <= hold_req + 1;
        // sender pauses until every owed word has been taken
        if (p == 2 && msgs == 8) settle();
      end
    end

    // closing part: no idling, a few good messages, then one fatal fault
    no_idle = 1'b1;
    reg_write(LIMIT_ADDR, 16'($urandom_range(8, 1000)));
    repeat (3) send_message(16'($urandom_range(limit, 0)), 16'($urandom_range(6, 0)));
    fault = fault_t'($urandom_range(0, 4));
    case (fault)
      FAULT_LINK_HEADER: begin
        // header left partly assembled
        cut = $urandom_range(0, 3);
        for (int i = 0; i < cut; i++) offer_byte(8'($urandom), 1'b0);
        offer_byte(8'($urandom), 1'b1);
      end
      FAULT_LINK_PAYLOAD: begin
        len = 16'($urandom_range(2, 6));
        send_header(16'($urandom_range(limit, 0)), len);
        cut = $urandom_range(0, len - 1);
        for (int i = 0; i < cut; i++) offer_byte(8'($urandom), 1'b0);
        offer_byte(8'($urandom), 1'b1);
      end
      FAULT_ID: send_header(16'($urandom_range(limit + 1, 65535)), 16'($urandom));
      FAULT_LEN: send_header(16'($urandom_range(limit, 0)),
                             16'($urandom_range(limit + 1, 65535)));
      default: begin
        // both over the limit, the id check comes first
        send_header(16'($urandom_range(limit + 1, 65535)),
                    16'($urandom_range(limit + 1, 65535)));
      end
    endcase
    // halted: bytes are dropped with or without a link error
    for (int i = 0; i < 20; i++) offer_byte(8'($urandom), (i % 3) == 0);

    // drain, then allow for bytes still in the pipe
    push <= 1'b0;
    waited = 0;
    while (expected_words.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * FLIGHT) @(posedge clk);
    if (expected_words.size() != 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0d expected words never arrived", expected_words.size());
    end
    if (mismatches == 0) begin
      $display("length_prefixed_message_deframer_core verification clean");
    end else begin
      $display("length_prefixed_message_deframer_core verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("length_prefixed_message_deframer_core verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/lpmd_pkg.sv
rtl/lpmd_front.sv
rtl/lpmd_queue.sv
rtl/lpmd_back.sv
rtl/length_prefixed_message_deframer_core.sv
test/length_prefixed_message_deframer_core_test.sv
